[design/ppr_pkg.sv]
`timescale 1ns / 1ps
// shared constants, request and result types, and curve root constants for the phase ramp
package ppr_pkg;

	localparam int POSITION_BITS   = 24;
	localparam int PHASE_FRAC_BITS = 24;
	localparam int DIFF_BITS       = (POSITION_BITS > 24) ? POSITION_BITS : 24;
	localparam int RX_BITS         = 32 + POSITION_BITS;
	localparam int LOG_FRAC        = 24;

	typedef enum logic [1:0] {
		CFG_END_RATE     = 2'd0,
		CFG_RAMP_LENGTH  = 2'd1,
		CFG_TOTAL_CYCLES = 2'd2,
		CFG_CURVE_POWER  = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [POSITION_BITS-1:0] position;
		logic                     block_end;
	} request_t;

	typedef struct packed {
		logic [PHASE_FRAC_BITS-1:0] phase;
		logic                       block_end_out;
	} result_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bt;
		logic [63:0] rem;
		res = 64'd0;
		bt  = 64'h4000_0000_0000_0000;
		rem = v;
		for (int j = 0; j < 32; j++) begin
			if (bt > rem) bt = bt >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (bt != 64'd0) begin
				if (rem >= res + bt) begin
					rem = rem - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
		end
		return res;
	endfunction

	// 2^(2^-i) in Q1.31, by repeated square roots of 2
	function automatic logic [31:0] root_const(int i);
		logic [63:0] c;
		c = 64'h1_0000_0000;
		for (int j = 1; j <= LOG_FRAC; j++) begin
			if (j <= i) c = isqrt64(c << 31);
		end
		return c[31:0];
	endfunction

endpackage

[design/polynomial_phase_ramp.sv]
`timescale 1ns / 1ps
// polynomial phase ramp: fully pipelined wrapped phase per sample position
// throughput: one request per cycle, busy is always low
// stages: input, 11 divider (leading bit, then 3 quotient bits each), 25 log2 squaring,
// 25 exp2 product, 5 curve/partial product, output
// reset clears all valid bits and loads register defaults; results cannot be stalled
module polynomial_phase_ramp
	import ppr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  request_t    request,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int DIV_STEPS  = 3;
	localparam int DIV_STAGES = 30 / DIV_STEPS;
	localparam int TOT_BITS   = 108;

	typedef struct packed {
		logic               be;
		logic [RX_BITS-1:0] rx;
		logic               sat;
		logic [23:0]        rem;
		logic [30:0]        q;
	} div_t;

	typedef struct packed {
		logic               be;
		logic [RX_BITS-1:0] rx;
		logic               uz;
		logic [4:0]         n;
		logic [31:0]        m;
		logic [23:0]        fr;
	} log_t;

	typedef struct packed {
		logic               be;
		logic [RX_BITS-1:0] rx;
		logic               uz;
		logic [12:0]        k;
		logic [23:0]        f;
		logic [31:0]        acc;
	} exp_t;

	typedef struct packed {
		logic               be;
		logic [RX_BITS-1:0] rx;
		logic               bneg;
		logic [47:0]        bm;
		logic [103:0]       acc;
	} mul_t;

	logic [31:0] end_rate_q;
	logic [23:0] ramp_length_q;
	logic [31:0] total_cycles_q;
	logic [15:0] curve_power_q;
	logic [55:0] rl_q;
	logic [55:0] dm_q;
	logic        dneg_q;

	logic                     v_s1;
	logic [POSITION_BITS-1:0] x_s1;
	logic                     be_s1;

	div_t div_s [0:DIV_STAGES];
	logic div_v [0:DIV_STAGES];
	log_t log_s [0:LOG_FRAC];
	logic log_v [0:LOG_FRAC];
	exp_t exp_s [0:LOG_FRAC];
	logic exp_v [0:LOG_FRAC];
	mul_t mul_s [0:4];
	logic mul_v [0:4];

	logic    done_q;
	result_t result_q;

	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = result_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_rate_q     <= 32'd0;
			ramp_length_q  <= 24'd44100;
			total_cycles_q <= 32'd65536;
			curve_power_q  <= 16'd4096;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_END_RATE:     end_rate_q     <= cfg_data;
				CFG_RAMP_LENGTH:  ramp_length_q  <= cfg_data[23:0];
				CFG_TOTAL_CYCLES: total_cycles_q <= cfg_data;
				CFG_CURVE_POWER:  curve_power_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// rate times length minus total, static between writes
	logic [55:0] zq;
	assign zq = {8'd0, total_cycles_q, 16'd0};

	always_ff @(posedge clk) begin
		rl_q   <= 56'(end_rate_q) * 56'(ramp_length_q);
		dneg_q <= rl_q < zq;
		dm_q   <= (rl_q < zq) ? zq - rl_q : rl_q - zq;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i <= DIV_STAGES; i++) div_v[i] <= 1'b0;
			for (int i = 0; i <= LOG_FRAC; i++) begin
				log_v[i] <= 1'b0;
				exp_v[i] <= 1'b0;
			end
			for (int i = 0; i <= 4; i++) mul_v[i] <= 1'b0;
		end else begin
			v_s1     <= start;
			div_v[0] <= v_s1;
			for (int i = 0; i < DIV_STAGES; i++) div_v[i+1] <= div_v[i];
			log_v[0] <= div_v[DIV_STAGES];
			for (int i = 0; i < LOG_FRAC; i++) log_v[i+1] <= log_v[i];
			exp_v[0] <= log_v[LOG_FRAC];
			for (int i = 0; i < LOG_FRAC; i++) exp_v[i+1] <= exp_v[i];
			mul_v[0] <= exp_v[LOG_FRAC];
			for (int i = 0; i < 4; i++) mul_v[i+1] <= mul_v[i];
			done_q <= mul_v[4];
		end
	end

	always_ff @(posedge clk) begin
		x_s1  <= request.position;
		be_s1 <= request.block_end;
	end

	// distance from ramp end, saturation and leading quotient bit
	logic [DIFF_BITS-1:0] x_ext;
	logic [DIFF_BITS-1:0] len_ext;
	logic [DIFF_BITS-1:0] diff;
	logic                 q_top;

	assign x_ext   = DIFF_BITS'(x_s1);
	assign len_ext = DIFF_BITS'(ramp_length_q);
	assign diff    = (x_ext >= len_ext) ? x_ext - len_ext : len_ext - x_ext;
	assign q_top   = diff >= len_ext;

	always_ff @(posedge clk) begin
		div_s[0].be  <= be_s1;
		div_s[0].rx  <= RX_BITS'(end_rate_q) * RX_BITS'(x_s1);
		div_s[0].sat <= {1'b0, diff} >= (DIFF_BITS+1)'({ramp_length_q, 1'b0});
		div_s[0].rem <= 24'(diff - (q_top ? len_ext : DIFF_BITS'(0)));
		div_s[0].q   <= {30'd0, q_top};
	end

	// restoring division, a few quotient bits per stage
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [23:0]          rm [0:DIV_STEPS];
		logic [DIV_STEPS-1:0] qb;

		always_comb begin
			rm[0] = div_s[k].rem;
			for (int j = 0; j < DIV_STEPS; j++) begin
				if ({rm[j], 1'b0} >= {1'b0, ramp_length_q}) begin
					qb[DIV_STEPS-1-j] = 1'b1;
					rm[j+1] = 24'({rm[j], 1'b0} - {1'b0, ramp_length_q});
				end else begin
					qb[DIV_STEPS-1-j] = 1'b0;
					rm[j+1] = {rm[j][22:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			div_s[k+1].be  <= div_s[k].be;
			div_s[k+1].rx  <= div_s[k].rx;
			div_s[k+1].sat <= div_s[k].sat;
			div_s[k+1].rem <= rm[DIV_STEPS];
			div_s[k+1].q   <= {div_s[k].q[30-DIV_STEPS:0], qb};
		end
	end

	// normalize u to a Q1.31 mantissa
	logic [31:0] u;
	logic [4:0]  lead;

	assign u = div_s[DIV_STAGES].sat ? 32'h8000_0000 : {1'b0, div_s[DIV_STAGES].q};

	always_comb begin
		lead = 5'd0;
		for (int j = 0; j < 32; j++) begin
			if (u[j]) lead = 5'(j);
		end
	end

	always_ff @(posedge clk) begin
		log_s[0].be <= div_s[DIV_STAGES].be;
		log_s[0].rx <= div_s[DIV_STAGES].rx;
		log_s[0].uz <= u == 32'd0;
		log_s[0].n  <= lead;
		log_s[0].m  <= u << (5'd31 - lead);
		log_s[0].fr <= 24'd0;
	end

	// log2 fraction bits by repeated squaring
	for (genvar i = 0; i < LOG_FRAC; i++) begin : g_log
		logic [63:0] sq;

		assign sq = 64'(log_s[i].m) * 64'(log_s[i].m);

		always_ff @(posedge clk) begin
			log_s[i+1].be <= log_s[i].be;
			log_s[i+1].rx <= log_s[i].rx;
			log_s[i+1].uz <= log_s[i].uz;
			log_s[i+1].n  <= log_s[i].n;
			log_s[i+1].m  <= sq[63] ? sq[63:32] : sq[62:31];
			log_s[i+1].fr <= {log_s[i].fr[22:0], sq[63]};
		end
	end

	// t = p * log2 u, floored to Q.24
	logic [5:0]         lg_int;
	logic signed [31:0] lg;
	logic signed [48:0] pl;
	logic [36:0]        t;

	assign lg_int = {1'b0, log_s[LOG_FRAC].n} - 6'd30;
	assign lg     = {{2{lg_int[5]}}, lg_int, log_s[LOG_FRAC].fr};
	assign pl     = $signed({1'b0, curve_power_q}) * lg;
	assign t      = 37'(pl >>> 12);

	always_ff @(posedge clk) begin
		exp_s[0].be  <= log_s[LOG_FRAC].be;
		exp_s[0].rx  <= log_s[LOG_FRAC].rx;
		exp_s[0].uz  <= log_s[LOG_FRAC].uz;
		exp_s[0].k   <= t[36:24];
		exp_s[0].f   <= t[23:0];
		exp_s[0].acc <= 32'h8000_0000;
	end

	// exp2 of the fraction as a product of roots of two
	for (genvar i = 0; i < LOG_FRAC; i++) begin : g_exp
		localparam logic [31:0] ROOT = root_const(i + 1);
		logic [63:0] prod;

		assign prod = 64'(exp_s[i].acc) * 64'(ROOT);

		always_ff @(posedge clk) begin
			exp_s[i+1].be  <= exp_s[i].be;
			exp_s[i+1].rx  <= exp_s[i].rx;
			exp_s[i+1].uz  <= exp_s[i].uz;
			exp_s[i+1].k   <= exp_s[i].k;
			exp_s[i+1].f   <= exp_s[i].f;
			exp_s[i+1].acc <= exp_s[i].f[LOG_FRAC-1-i] ? prod[62:31] : exp_s[i].acc;
		end
	end

	// scale by 2^k and form |u^p - 1|
	logic signed [13:0] e;
	logic [13:0]        ne;
	logic [47:0]        w;

	assign e  = $signed({exp_s[LOG_FRAC].k[12], exp_s[LOG_FRAC].k}) - 14'sd1;
	assign ne = 14'(-e);

	always_comb begin
		if (!e[13]) w = 48'({16'd0, exp_s[LOG_FRAC].acc} << e[3:0]);
		else if (ne >= 14'd32) w = 48'd0;
		else w = 48'(exp_s[LOG_FRAC].acc >> ne[4:0]);
		if (curve_power_q == 16'd0) w = 48'h4000_0000;
		else if (exp_s[LOG_FRAC].uz) w = 48'd0;
	end

	always_ff @(posedge clk) begin
		mul_s[0].be   <= exp_s[LOG_FRAC].be;
		mul_s[0].rx   <= exp_s[LOG_FRAC].rx;
		mul_s[0].bneg <= w < 48'h4000_0000;
		mul_s[0].bm   <= (w < 48'h4000_0000) ? 48'h4000_0000 - w : w - 48'h4000_0000;
		mul_s[0].acc  <= 104'd0;
	end

	// 56 x 48 product as four partial products
	for (genvar j = 0; j < 4; j++) begin : g_mul
		localparam int SH = 28 * (j % 2) + 24 * (j / 2);
		logic [27:0] dh;
		logic [23:0] bh;
		logic [51:0] pp;

		assign dh = (j % 2 == 1) ? dm_q[55:28] : dm_q[27:0];
		assign bh = (j / 2 == 1) ? mul_s[j].bm[47:24] : mul_s[j].bm[23:0];
		assign pp = 52'(dh) * 52'(bh);

		always_ff @(posedge clk) begin
			mul_s[j+1].be   <= mul_s[j].be;
			mul_s[j+1].rx   <= mul_s[j].rx;
			mul_s[j+1].bneg <= mul_s[j].bneg;
			mul_s[j+1].bm   <= mul_s[j].bm;
			mul_s[j+1].acc  <= mul_s[j].acc + (104'(pp) << SH);
		end
	end

	// signed total, clamp and wrap
	logic [TOT_BITS-1:0] mag;
	logic [TOT_BITS-1:0] tot;

	assign mag = TOT_BITS'(mul_s[4].acc);
	assign tot = ((dneg_q != mul_s[4].bneg) ? -mag : mag) + (TOT_BITS'(mul_s[4].rx) << 30);

	always_ff @(posedge clk) begin
		result_q.phase         <= tot[TOT_BITS-1] ? '0 : tot[61 -: PHASE_FRAC_BITS];
		result_q.block_end_out <= mul_s[4].be;
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// self-checking bench for the polynomial phase ramp: directed table, random bursts, model compare
module tb;
	import ppr_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	request_t    request;
	logic        done;
	result_t     result;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	localparam int LATENCY = 68;
	localparam int LIMIT   = 400000;

	logic [31:0] rate_q;
	logic [23:0] len_q;
	logic [31:0] cycles_q;
	logic [15:0] power_q;

	result_t phase_queue[$];
	int      errors;
	int      cycle_count;

	polynomial_phase_ramp dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bt;
		res = 0;
		bt  = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v   = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// u^p in Q.30 via log2 / exp2
	function automatic logic [63:0] curve_pow(logic [63:0] u, logic [15:0] p);
		int                 n;
		int                 e;
		logic [63:0]        m;
		logic [63:0]        fr;
		logic [63:0]        c;
		logic [63:0]        acc;
		logic signed [63:0] lg;
		logic signed [63:0] t;
		logic signed [63:0] k;
		logic signed [63:0] f;
		n  = 31;
		fr = 0;
		while (n > 0 && u[n] == 1'b0) n--;
		m = u << (31 - n);
		for (int i = 0; i < 24; i++) begin
			m  = (m * m) >> 31;
			fr = fr << 1;
			if (m >= (64'd1 << 32)) begin
				fr[0] = 1'b1;
				m     = m >> 1;
			end
		end
		lg  = (64'(n) - 30) * (64'sd1 <<< 24) + $signed(fr);
		t   = ($signed({48'd0, p}) * lg) >>> 12;
		k   = t >>> 24;
		f   = t - (k <<< 24);
		acc = 64'd1 << 31;
		c   = 64'd1 << 32;
		for (int i = 1; i <= 24; i++) begin
			c = int_sqrt(c << 31);
			if (f[24 - i]) acc = (acc * c) >> 31;
		end
		e = int'(k) - 1;
		if (e >= 0) return acc << e;
		if (-e >= 64) return 0;
		return acc >> (-e);
	endfunction

	function automatic result_t ramp_phase(request_t req);
		logic [63:0]         x;
		logic [63:0]         ln;
		logic [63:0]         diff;
		logic [63:0]         u;
		logic [63:0]         w;
		logic signed [127:0] d;
		logic signed [127:0] b;
		logic signed [127:0] total;
		result_t             res;
		x    = req.position;
		ln   = len_q;
		diff = (x >= ln) ? x - ln : ln - x;
		if (ln == 0) u = 64'd1 << 31;
		else begin
			u = (diff << 30) / ln;
			if (u > (64'd1 << 31)) u = 64'd1 << 31;
		end
		if (power_q == 0) w = 64'd1 << 30;
		else if (u == 0) w = 0;
		else w = curve_pow(u, power_q);
		d     = $signed({64'd0, 64'(rate_q) * ln}) - $signed({64'd0, 64'(cycles_q) << 16});
		b     = $signed({64'd0, w}) - $signed(128'd1 << 30);
		total = d * b + ($signed({64'd0, 64'(rate_q) * x}) <<< 30);
		res.phase         = total[127] ? '0 : total[61:38];
		res.block_end_out = req.block_end;
		return res;
	endfunction

	always @(posedge clk) begin
		result_t exp_r;
		if (done) begin
			if (phase_queue.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, result);
				errors++;
			end else begin
				exp_r = phase_queue.pop_front();
				if (result.phase !== exp_r.phase) begin
					$display("%0t phase: expected %h, actual %h", $time, exp_r.phase,
						result.phase);
					errors++;
				end
				if (result.block_end_out !== exp_r.block_end_out) begin
					$display("%0t block_end_out: expected %b, actual %b", $time,
						exp_r.block_end_out, result.block_end_out);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(cfg_index_t idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_END_RATE:     rate_q   = val;
			CFG_RAMP_LENGTH:  len_q    = val[23:0];
			CFG_TOTAL_CYCLES: cycles_q = val;
			default:          power_q  = val[15:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		while (phase_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// sends one request, with an idle gap of the given length before it when gap is above zero
	task automatic send(request_t req, int gap, logic has_exp, logic [23:0] exp_phase);
		result_t exp_r;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy) @(posedge clk);
		exp_r = ramp_phase(req);
		if (has_exp && exp_r.phase !== exp_phase) begin
			$display("%0t directed phase: expected %h, actual %h", $time, exp_phase,
				exp_r.phase);
			errors++;
		end
		phase_queue.push_back(exp_r);
	endtask

	task automatic stop();
		start <= 1'b0;
		@(posedge clk);
	endtask

	typedef struct {
		logic [23:0] position;
		logic        block_end;
		logic        has_exp;
		logic [23:0] phase;
	} row_t;

	row_t rows[$];

	task automatic random_phase(int count, int max_pos);
		request_t req;
		int       burst;
		int       gap;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			gap = 0;
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
			burst--;
			req.position  = ($urandom_range(0, 7) == 0) ? 24'($urandom)
				: 24'($urandom_range(0, max_pos));
			req.block_end = 1'($urandom);
			send(req, gap, 1'b0, '0);
		end
		stop();
		drain();
	endtask

	initial begin
		request_t req;
		errors      = 0;
		cycle_count = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		request     = '0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_END_RATE;
		cfg_data    = '0;
		rate_q      = 0;
		len_q       = 44100;
		cycles_q    = 65536;
		power_q     = 4096;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset r = 0, so phase is frac(-z*(u-1)); at x = 0 and x = L it is zero
		rows.push_back('{24'd0, 1'b0, 1'b1, 24'd0});
		rows.push_back('{24'd44100, 1'b1, 1'b1, 24'd0});
		rows.push_back('{24'd88200, 1'b0, 1'b0, 24'd0});
		rows.push_back('{24'hFFFFFF, 1'b1, 1'b0, 24'd0});
		rows.push_back('{24'd22050, 1'b0, 1'b0, 24'd0});
		rows.push_back('{24'd1, 1'b1, 1'b0, 24'd0});
		foreach (rows[i]) begin
			req.position  = rows[i].position;
			req.block_end = rows[i].block_end;
			send(req, i % 2, rows[i].has_exp, rows[i].phase);
		end
		stop();
		drain();

		// zero power, zero and max length, max and zero rate, negative totals
		write_reg(CFG_CURVE_POWER, 32'd0);
		write_reg(CFG_END_RATE, 32'hFFFF_FFFF);
		foreach (rows[i]) begin
			req.position  = rows[i].position;
			req.block_end = rows[i].block_end;
			send(req, 0, 1'b0, '0);
		end
		stop();
		drain();
		write_reg(CFG_RAMP_LENGTH, 32'd0);
		write_reg(CFG_CURVE_POWER, 32'hFFFF);
		write_reg(CFG_TOTAL_CYCLES, 32'hFFFF_FFFF);
		foreach (rows[i]) begin
			req.position  = rows[i].position;
			req.block_end = rows[i].block_end;
			send(req, 0, 1'b0, '0);
		end
		stop();
		drain();
		write_reg(CFG_RAMP_LENGTH, 32'hFFFFFF);
		write_reg(CFG_END_RATE, 32'd0);
		write_reg(CFG_TOTAL_CYCLES, 32'd0);
		foreach (rows[i]) begin
			req.position  = rows[i].position;
			req.block_end = rows[i].block_end;
			send(req, 0, 1'b0, '0);
		end
		stop();
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_END_RATE, (ph == 1) ? 32'hFFFF_FFFF : 32'($urandom));
			write_reg(CFG_RAMP_LENGTH, (ph == 2) ? 32'd1 : 32'($urandom_range(1, 200000)));
			write_reg(CFG_TOTAL_CYCLES, (ph == 3) ? 32'd0 : 32'($urandom));
			write_reg(CFG_CURVE_POWER, (ph == 4) ? 32'd1 : 32'($urandom_range(1, 65535)));
			random_phase(90, 2 * int'(len_q) + 2);
		end

		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
